[rtl/core/mfso_pkg.sv]
// ----------------------------------------------------------------------------
// mfso_pkg
// Shared types, codes and helpers for the matrix fill scan order generator.
// ----------------------------------------------------------------------------
package mfso_pkg;

  // largest supported side length
  localparam int MAX_SIZE   = 64;

  // field widths
  localparam int IDX_W      = 6;
  localparam int SIZE_W     = 7;
  localparam int VAL_W      = 13;
  localparam int MODE_W     = 3;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [VAL_W-1:0]      val_t;
  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [DIR_W-1:0]      dir_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_MATRIX_SIZE = 2'd0;
  localparam cfg_idx_t REG_FILL_MODE   = 2'd1;

  // fill modes
  localparam mode_t MODE_PRODUCT     = 3'd0;
  localparam mode_t MODE_REV_PRODUCT = 3'd1;
  localparam mode_t MODE_ANTI_DIAG   = 3'd2;
  localparam mode_t MODE_RIGHT_DIAG  = 3'd3;
  localparam mode_t MODE_SPIRAL      = 3'd4;

  // spiral directions
  localparam dir_t DIR_RIGHT = 2'd0;
  localparam dir_t DIR_DOWN  = 2'd1;
  localparam dir_t DIR_LEFT  = 2'd2;
  localparam dir_t DIR_UP    = 2'd3;

  // settings seen by the walker
  typedef struct packed {
    size_t n;
    idx_t  last_idx;
    mode_t mode;
    val_t  n_sq;
    logic  clear;
  } cfg_ctl_t;

  // one cell between the walker and the value stage
  typedef struct packed {
    idx_t  row;
    idx_t  col;
    val_t  seq;
    size_t n;
    mode_t mode;
    logic  last;
  } cell_t;

  // size zero acts as one, sizes above the maximum saturate
  function automatic size_t clamp_size(input size_t raw);
    size_t res;
    if (raw == '0) begin
      res = SIZE_W'(1);
    end else if (raw > SIZE_W'(MAX_SIZE)) begin
      res = SIZE_W'(MAX_SIZE);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

[rtl/core/mfso_ifs.sv]
// ----------------------------------------------------------------------------
// mfso channel interfaces
// Valid/ready channels for configuration, requests and cell results.
// ----------------------------------------------------------------------------
interface mfso_cfg_if;
  import mfso_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

interface mfso_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source(output valid, output restart, input ready);
  modport sink(input valid, input restart, output ready);
endinterface

interface mfso_rsp_if;
  import mfso_pkg::*;
  logic valid;
  logic ready;
  idx_t row;
  idx_t col;
  val_t value;
  logic last;
  modport source(output valid, output row, output col, output value, output last,
                 input ready);
  modport sink(input valid, input row, input col, input value, input last,
               output ready);
endinterface

[rtl/core/mfso_cfg.sv]
// ----------------------------------------------------------------------------
// mfso_cfg
// Configuration registers, size clamp and precomputed cell count.
// ----------------------------------------------------------------------------
module mfso_cfg (
  input  logic              clk,
  input  logic              rst,
  mfso_cfg_if.sink          cfg,
  output mfso_pkg::cfg_ctl_t ctl
);
  import mfso_pkg::*;

  size_t matrix_size;
  mode_t fill_mode;
  val_t  n_sq;
  size_t wr_size;
  logic  we;

  // writes are always taken
  assign cfg.ready = 1'b1;
  assign we        = cfg.valid;
  assign wr_size   = clamp_size(cfg.data);

  // register file, cell count follows a size write
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_W'(8);
      fill_mode   <= MODE_PRODUCT;
      n_sq        <= VAL_W'(64);
    end else if (we) begin
      unique case (cfg.index)
        REG_MATRIX_SIZE: begin
          matrix_size <= cfg.data;
          n_sq        <= VAL_W'(wr_size) * VAL_W'(wr_size);
        end
        REG_FILL_MODE: begin
          fill_mode <= cfg.data[MODE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // settings handed to the walker
  always_comb begin
    ctl.n        = clamp_size(matrix_size);
    ctl.last_idx = IDX_W'(ctl.n - SIZE_W'(1));
    ctl.mode     = (fill_mode > MODE_SPIRAL) ? MODE_PRODUCT : fill_mode;
    ctl.n_sq     = n_sq;
    ctl.clear    = we && (cfg.index == REG_MATRIX_SIZE || cfg.index == REG_FILL_MODE);
  end

endmodule

[rtl/core/mfso_walker.sv]
// ----------------------------------------------------------------------------
// mfso_walker
// Scan position state; steps once per accepted request into a cell register.
// ----------------------------------------------------------------------------
module mfso_walker (
  input  logic               clk,
  input  logic               rst,
  input  mfso_pkg::cfg_ctl_t ctl,
  mfso_req_if.sink           req,
  input  logic               cell_ready,
  output logic               cell_valid,
  output mfso_pkg::cell_t    cell_data
);
  import mfso_pkg::*;

  logic started;
  idx_t cur_row, cur_col;
  val_t seq_count;
  idx_t diag_origin_row, diag_origin_col;
  logic diag_phase;
  idx_t bound_top, bound_bottom, bound_left, bound_right;
  dir_t spiral_dir;

  idx_t cur_row_next, cur_col_next;
  val_t seq_count_next;
  idx_t diag_origin_row_next, diag_origin_col_next;
  logic diag_phase_next;
  idx_t bound_top_next, bound_bottom_next, bound_left_next, bound_right_next;
  dir_t spiral_dir_next;
  logic is_last;

  logic load_ok;
  logic accept;

  assign load_ok   = !cell_valid || cell_ready;
  assign req.ready = load_ok;
  assign accept    = req.valid && load_ok;

  // next scan position
  always_comb begin
    cur_row_next         = cur_row;
    cur_col_next         = cur_col;
    diag_origin_row_next = diag_origin_row;
    diag_origin_col_next = diag_origin_col;
    diag_phase_next      = diag_phase;
    bound_top_next       = bound_top;
    bound_bottom_next    = bound_bottom;
    bound_left_next      = bound_left;
    bound_right_next     = bound_right;
    spiral_dir_next      = spiral_dir;
    seq_count_next       = seq_count + VAL_W'(1);
    if (req.restart || !started) begin
      seq_count_next       = VAL_W'(1);
      diag_phase_next      = 1'b0;
      diag_origin_row_next = '0;
      diag_origin_col_next = (ctl.mode == MODE_RIGHT_DIAG) ? ctl.last_idx : '0;
      cur_row_next         = '0;
      cur_col_next         = diag_origin_col_next;
      bound_top_next       = '0;
      bound_left_next      = '0;
      bound_bottom_next    = ctl.last_idx;
      bound_right_next     = ctl.last_idx;
      spiral_dir_next      = DIR_RIGHT;
    end else begin
      case (ctl.mode)
        MODE_ANTI_DIAG: begin
          if (!diag_phase) begin
            if (cur_row != '0) begin
              cur_row_next = cur_row - IDX_W'(1);
              cur_col_next = cur_col + IDX_W'(1);
            end else begin
              if (diag_origin_row == ctl.last_idx) begin
                diag_phase_next      = 1'b1;
                diag_origin_row_next = ctl.last_idx;
                diag_origin_col_next = IDX_W'(1);
              end else begin
                diag_origin_row_next = diag_origin_row + IDX_W'(1);
              end
              cur_row_next = diag_origin_row_next;
              cur_col_next = diag_origin_col_next;
            end
          end else begin
            if (cur_col < ctl.last_idx && cur_row != '0) begin
              cur_row_next = cur_row - IDX_W'(1);
              cur_col_next = cur_col + IDX_W'(1);
            end else begin
              diag_origin_col_next = diag_origin_col + IDX_W'(1);
              cur_row_next         = ctl.last_idx;
              cur_col_next         = diag_origin_col_next;
            end
          end
        end
        MODE_RIGHT_DIAG: begin
          if (cur_row != '0 && cur_col != '0) begin
            cur_row_next = cur_row - IDX_W'(1);
            cur_col_next = cur_col - IDX_W'(1);
          end else if (!diag_phase) begin
            if (diag_origin_row == ctl.last_idx) begin
              diag_phase_next      = 1'b1;
              diag_origin_row_next = ctl.last_idx;
              diag_origin_col_next = ctl.last_idx - IDX_W'(1);
            end else begin
              diag_origin_row_next = diag_origin_row + IDX_W'(1);
            end
            cur_row_next = diag_origin_row_next;
            cur_col_next = diag_origin_col_next;
          end else begin
            diag_origin_col_next = diag_origin_col - IDX_W'(1);
            cur_row_next         = ctl.last_idx;
            cur_col_next         = diag_origin_col_next;
          end
        end
        MODE_SPIRAL: begin
          case (spiral_dir)
            DIR_RIGHT: begin
              if (cur_col < bound_right) begin
                cur_col_next = cur_col + IDX_W'(1);
              end else begin
                bound_top_next  = bound_top + IDX_W'(1);
                spiral_dir_next = DIR_DOWN;
                cur_row_next    = cur_row + IDX_W'(1);
              end
            end
            DIR_DOWN: begin
              if (cur_row < bound_bottom) begin
                cur_row_next = cur_row + IDX_W'(1);
              end else begin
                bound_right_next = bound_right - IDX_W'(1);
                spiral_dir_next  = DIR_LEFT;
                cur_col_next     = cur_col - IDX_W'(1);
              end
            end
            DIR_LEFT: begin
              if (cur_col > bound_left) begin
                cur_col_next = cur_col - IDX_W'(1);
              end else begin
                bound_bottom_next = bound_bottom - IDX_W'(1);
                spiral_dir_next   = DIR_UP;
                cur_row_next      = cur_row - IDX_W'(1);
              end
            end
            default: begin
              if (cur_row > bound_top) begin
                cur_row_next = cur_row - IDX_W'(1);
              end else begin
                bound_left_next = bound_left + IDX_W'(1);
                spiral_dir_next = DIR_RIGHT;
                cur_col_next    = cur_col + IDX_W'(1);
              end
            end
          endcase
        end
        default: begin
          if (cur_col < ctl.last_idx) begin
            cur_col_next = cur_col + IDX_W'(1);
          end else begin
            cur_col_next = '0;
            cur_row_next = cur_row + IDX_W'(1);
          end
        end
      endcase
    end
    is_last = seq_count_next >= ctl.n_sq;
  end

  // scan state, updated on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      cur_row         <= '0;
      cur_col         <= '0;
      seq_count       <= '0;
      diag_origin_row <= '0;
      diag_origin_col <= '0;
      diag_phase      <= 1'b0;
      bound_top       <= '0;
      bound_bottom    <= '0;
      bound_left      <= '0;
      bound_right     <= '0;
      spiral_dir      <= DIR_RIGHT;
    end else begin
      // a register write wins over a step
      if (ctl.clear) begin
        started <= 1'b0;
      end else if (accept) begin
        started <= !is_last;
      end
      if (accept) begin
        cur_row         <= cur_row_next;
        cur_col         <= cur_col_next;
        seq_count       <= seq_count_next;
        diag_origin_row <= diag_origin_row_next;
        diag_origin_col <= diag_origin_col_next;
        diag_phase      <= diag_phase_next;
        bound_top       <= bound_top_next;
        bound_bottom    <= bound_bottom_next;
        bound_left      <= bound_left_next;
        bound_right     <= bound_right_next;
        spiral_dir      <= spiral_dir_next;
      end
    end
  end

  // cell register toward the value stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (load_ok) begin
      cell_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell_data.row  <= cur_row_next;
      cell_data.col  <= cur_col_next;
      cell_data.seq  <= seq_count_next;
      cell_data.n    <= ctl.n;
      cell_data.mode <= ctl.mode;
      cell_data.last <= is_last;
    end
  end

  // a restart always produces the first cell
  a_restart_first: assert property (@(posedge clk) disable iff (rst)
    accept && req.restart |=> cell_valid && cell_data.seq == VAL_W'(1))
    else $error("restart did not produce the first cell");

  // a register write forces the next word to begin a pattern
  a_clear_started: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> !started)
    else $error("config write did not clear the pattern");

  // sequence numbers start at one
  a_seq_nonzero: assert property (@(posedge clk) disable iff (rst)
    cell_valid |-> cell_data.seq != '0)
    else $error("cell with zero sequence number");

  // a cell marked last ends the pattern
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    accept && is_last |=> !started)
    else $error("pattern still running after its last cell");

endmodule

[rtl/core/mfso_value.sv]
// ----------------------------------------------------------------------------
// mfso_value
// Cell value computation and output register.
// ----------------------------------------------------------------------------
module mfso_value (
  input  logic            clk,
  input  logic            rst,
  input  logic            cell_valid,
  input  mfso_pkg::cell_t cell_data,
  output logic            cell_ready,
  mfso_rsp_if.source      rsp
);
  import mfso_pkg::*;

  size_t opa, opb;
  logic [2*SIZE_W-1:0] prod;
  val_t  value_next;
  logic  take;

  logic  out_valid;
  idx_t  out_row, out_col;
  val_t  out_value;
  logic  out_last;

  assign cell_ready = !out_valid || rsp.ready;
  assign take       = cell_valid && cell_ready;

  // one shared multiplier for both product modes
  always_comb begin
    if (cell_data.mode == MODE_REV_PRODUCT) begin
      opa = cell_data.n - {1'b0, cell_data.row};
      opb = cell_data.n - {1'b0, cell_data.col};
    end else begin
      opa = {1'b0, cell_data.row} + SIZE_W'(1);
      opb = {1'b0, cell_data.col} + SIZE_W'(1);
    end
    prod = opa * opb;
    if (cell_data.mode == MODE_PRODUCT || cell_data.mode == MODE_REV_PRODUCT) begin
      value_next = prod[VAL_W-1:0];
    end else begin
      value_next = cell_data.seq;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cell_ready) begin
      out_valid <= cell_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_row   <= cell_data.row;
      out_col   <= cell_data.col;
      out_value <= value_next;
      out_last  <= cell_data.last;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.row   = out_row;
  assign rsp.col   = out_col;
  assign rsp.value = out_value;
  assign rsp.last  = out_last;

endmodule

[rtl/core/matrix_fill_scan_order_generator_unit.sv]
// ----------------------------------------------------------------------------
// matrix_fill_scan_order_generator_unit
// Emits the cells of an N-by-N matrix fill in one of five scan orders.
// ----------------------------------------------------------------------------
// Each request word yields exactly one cell word (row, col, value, last).
// Throughput is one word per clock when rsp is not stalling. From request
// acceptance a cell passes first the walker's cell register (the walker
// holds the scan position and steps it on every accepted request), then
// the value stage, whose single 7x7 multiplier forms product-mode values.
// Both stages are registered and back-pressure from rsp stalls them without
// losing words. Configuration writes are taken every cycle; a write to
// either register makes the next request start the pattern from its first
// cell. After the cell marked last the pattern starts over.
module matrix_fill_scan_order_generator_unit (
  input  logic        clk,
  input  logic        rst,
  mfso_cfg_if.sink    cfg,
  mfso_req_if.sink    req,
  mfso_rsp_if.source  rsp
);
  import mfso_pkg::*;

  cfg_ctl_t ctl;
  cell_t    cell_data;
  logic     cell_valid;
  logic     cell_ready;

  // configuration registers
  mfso_cfg u_cfg (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .ctl (ctl)
  );

  // scan position walker
  mfso_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .req        (req),
    .cell_ready (cell_ready),
    .cell_valid (cell_valid),
    .cell_data  (cell_data)
  );

  // value computation and output register
  mfso_value u_value (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_data  (cell_data),
    .cell_ready (cell_ready),
    .rsp        (rsp)
  );

endmodule
